### design/char_lcd_4bit_command_sequencer_unit_assert.svh
// ----------------------------------------------------------------------------
// Character LCD command sequencer - assertion macros
// Implication and next-cycle checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_4BIT_COMMAND_SEQUENCER_UNIT_ASSERT_SVH
`define CHAR_LCD_4BIT_COMMAND_SEQUENCER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define CLCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define CLCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CLCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define CLCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### design/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// Types, microcode word layout and constants of the character LCD sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

  typedef logic [3:0] pc_t;

  typedef enum logic [2:0] {
    ACT_INIT   = 3'd0,
    ACT_CMD    = 3'd1,
    ACT_DATA   = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_CURSOR = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    NIB_CONST  = 2'd0,
    NIB_REQ_HI = 2'd1,
    NIB_REQ_LO = 2'd2
  } nib_sel_t;

  typedef enum logic [1:0] {
    EXTRA_NONE  = 2'd0,
    EXTRA_PWRUP = 2'd1,
    EXTRA_FSET  = 2'd2,
    EXTRA_CLEAR = 2'd3
  } extra_t;

  typedef struct packed {
    nib_sel_t   nib_sel;
    logic [3:0] nib_const;
    logic       pre_long;
    extra_t     extra;
    logic       last;
  } cw_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } seq_state_t;

  typedef struct packed {
    logic load_req;
    logic step;
  } seq_ctl_t;

  localparam pc_t PC_INIT  = 4'd0;
  localparam pc_t PC_CLEAR = 4'd10;
  localparam pc_t PC_BYTE  = 4'd12;
  localparam pc_t PC_END   = 4'd13;

  localparam logic [15:0] PRE_PWRUP_US  = 16'd50000;
  localparam logic [12:0] POST_BASE_US  = 13'd100;
  localparam logic [12:0] POST_PWRUP_US = 13'd5100;
  localparam logic [12:0] POST_FSET_US  = 13'd250;
  localparam logic [12:0] POST_CLEAR_US = 13'd2100;

  localparam logic       CMD_SET_DDRAM = 1'b1;
  localparam logic [6:0] ROW1_BASE     = 7'h40;

endpackage

### design/char_lcd_4bit_command_sequencer_unit.sv
// ----------------------------------------------------------------------------
// char_lcd_4bit_command_sequencer_unit
// Turns LCD requests into 4-bit nibble transfer records for a timing layer.
//
//   channel  dir  handshake              beat
//   in_      in   in_valid / in_ready    one request
//   out_     out  out_valid / out_ready  one nibble transfer
//
// A request is taken while idle, then one transfer per cycle leaves while
// out_ready is high: init runs microcode steps 0 to 11, clear steps 10 and
// 11, the other requests steps 12 and 13, as walked by the step counter.
// in_ready rises once the last transfer of a request is registered.
// Undefined actions are taken and give no beat. Stalls on out_ready hold the step counter. Reset is synchronous.
// ----------------------------------------------------------------------------
module char_lcd_4bit_command_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_byte_value,
  input  logic        in_row,
  input  logic [5:0]  in_column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_register_select,
  output logic [3:0]  out_nibble,
  output logic [15:0] out_pre_wait_us,
  output logic [12:0] out_post_wait_us,
  output logic        out_last
);
  import clcd_pkg::*;

  pc_t      pc;
  cw_t      cw;
  seq_ctl_t ctl;

  clcd_urom u_urom (
    .pc (pc),
    .cw (cw)
  );

  clcd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cw        (cw),
    .pc        (pc),
    .ctl       (ctl)
  );

  clcd_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_action           (in_action),
    .in_byte_value       (in_byte_value),
    .in_row              (in_row),
    .in_column           (in_column),
    .cw                  (cw),
    .ctl                 (ctl),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_register_select (out_register_select),
    .out_nibble          (out_nibble),
    .out_pre_wait_us     (out_pre_wait_us),
    .out_post_wait_us    (out_post_wait_us),
    .out_last            (out_last)
  );

endmodule

### design/clcd_urom.sv
// ----------------------------------------------------------------------------
// clcd_urom
// Microcode store: one control word per transfer step.
// ----------------------------------------------------------------------------
module clcd_urom (
  input  clcd_pkg::pc_t pc,
  output clcd_pkg::cw_t cw
);
  import clcd_pkg::*;

  function automatic cw_t mk(input nib_sel_t sel, input logic [3:0] nib,
                             input logic pre_long, input extra_t extra,
                             input logic last);
    cw_t w;
    w.nib_sel   = sel;
    w.nib_const = nib;
    w.pre_long  = pre_long;
    w.extra     = extra;
    w.last      = last;
    return w;
  endfunction

  always_comb begin
    unique case (pc)
      4'd0:    cw = mk(NIB_CONST,  4'h3, 1'b1, EXTRA_PWRUP, 1'b0);
      4'd1:    cw = mk(NIB_CONST,  4'h3, 1'b0, EXTRA_FSET,  1'b0);
      4'd2:    cw = mk(NIB_CONST,  4'h3, 1'b0, EXTRA_NONE,  1'b0);
      4'd3:    cw = mk(NIB_CONST,  4'h2, 1'b0, EXTRA_NONE,  1'b0);
      4'd4:    cw = mk(NIB_CONST,  4'h2, 1'b0, EXTRA_NONE,  1'b0);
      4'd5:    cw = mk(NIB_CONST,  4'h8, 1'b0, EXTRA_NONE,  1'b0);
      4'd6:    cw = mk(NIB_CONST,  4'h0, 1'b0, EXTRA_NONE,  1'b0);
      4'd7:    cw = mk(NIB_CONST,  4'hC, 1'b0, EXTRA_NONE,  1'b0);
      4'd8:    cw = mk(NIB_CONST,  4'h0, 1'b0, EXTRA_NONE,  1'b0);
      4'd9:    cw = mk(NIB_CONST,  4'h6, 1'b0, EXTRA_NONE,  1'b0);
      4'd10:   cw = mk(NIB_CONST,  4'h0, 1'b0, EXTRA_NONE,  1'b0);
      4'd11:   cw = mk(NIB_CONST,  4'h1, 1'b0, EXTRA_CLEAR, 1'b1);
      4'd12:   cw = mk(NIB_REQ_HI, 4'h0, 1'b0, EXTRA_NONE,  1'b0);
      4'd13:   cw = mk(NIB_REQ_LO, 4'h0, 1'b0, EXTRA_NONE,  1'b1);
      default: cw = mk(NIB_CONST,  4'h0, 1'b0, EXTRA_NONE,  1'b1);
    endcase
  end

endmodule

### design/clcd_seq.sv
// ----------------------------------------------------------------------------
// clcd_seq
// Step counter and dispatch: picks the entry step per request, advances
// one step per output beat and stops on a word marked last.
// ----------------------------------------------------------------------------
`include "char_lcd_4bit_command_sequencer_unit_assert.svh"

module clcd_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic               out_valid,
  input  logic               out_ready,
  input  clcd_pkg::cw_t      cw,
  output clcd_pkg::pc_t      pc,
  output clcd_pkg::seq_ctl_t ctl
);
  import clcd_pkg::*;

  seq_state_t state_r, state_nxt;
  pc_t        pc_r, pc_nxt;
  pc_t        entry;
  logic       act_ok;
  logic       accept;

  always_comb begin
    entry  = PC_BYTE;
    act_ok = 1'b1;
    unique case (in_action) inside
      ACT_INIT:                     entry = PC_INIT;
      ACT_CLEAR:                    entry = PC_CLEAR;
      ACT_CMD, ACT_DATA, ACT_CURSOR: entry = PC_BYTE;
      default:                      act_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= PC_INIT;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    pc_nxt       = pc_r;
    in_ready     = 1'b0;
    accept       = 1'b0;
    ctl.load_req = 1'b0;
    ctl.step     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        accept   = in_valid;
        if (accept && act_ok) begin
          ctl.load_req = 1'b1;
          pc_nxt       = entry;
          state_nxt    = ST_RUN;
        end
      end
      ST_RUN: begin
        ctl.step = !out_valid || out_ready;
        if (ctl.step) begin
          pc_nxt = pc_r + 4'd1;
          if (cw.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign pc = pc_r;

  `CLCD_ASSERT_NXT(a_start, clk, rst_n, accept && act_ok, state_r == ST_RUN, "request not started")
  `CLCD_ASSERT_NXT(a_drop, clk, rst_n, accept && !act_ok, state_r == ST_IDLE, "bad action started")
  `CLCD_ASSERT_IMP(a_pc_range, clk, rst_n, state_r == ST_RUN, pc_r <= PC_END, "step out of program")
  `CLCD_ASSERT_NXT(a_finish, clk, rst_n, ctl.step && cw.last, state_r == ST_IDLE, "no stop on last")

endmodule

### design/clcd_datapath.sv
// ----------------------------------------------------------------------------
// clcd_datapath
// Request byte and RS hold, nibble and wait selection, output record register.
// ----------------------------------------------------------------------------
module clcd_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_action,
  input  logic [7:0]         in_byte_value,
  input  logic               in_row,
  input  logic [5:0]         in_column,
  input  clcd_pkg::cw_t      cw,
  input  clcd_pkg::seq_ctl_t ctl,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_register_select,
  output logic [3:0]         out_nibble,
  output logic [15:0]        out_pre_wait_us,
  output logic [12:0]        out_post_wait_us,
  output logic               out_last
);
  import clcd_pkg::*;

  logic [7:0]  req_byte_r;
  logic        rs_r;
  logic [6:0]  ddram_addr;
  logic [7:0]  req_byte;
  logic [3:0]  nib;
  logic [12:0] post_us;
  logic        out_valid_r;
  logic        rs_out_r;
  logic [3:0]  nibble_r;
  logic [15:0] pre_r;
  logic [12:0] post_r;
  logic        last_r;

  assign ddram_addr = (in_row ? ROW1_BASE : 7'h00) + {1'b0, in_column};
  assign req_byte   = (in_action == ACT_CURSOR) ? {CMD_SET_DDRAM, ddram_addr} : in_byte_value;

  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      req_byte_r <= req_byte;
      rs_r       <= (in_action == ACT_DATA);
    end
  end

  always_comb begin
    unique case (cw.nib_sel)
      NIB_REQ_HI: nib = req_byte_r[7:4];
      NIB_REQ_LO: nib = req_byte_r[3:0];
      default:    nib = cw.nib_const;
    endcase
    unique case (cw.extra)
      EXTRA_PWRUP: post_us = POST_PWRUP_US;
      EXTRA_FSET:  post_us = POST_FSET_US;
      EXTRA_CLEAR: post_us = POST_CLEAR_US;
      default:     post_us = POST_BASE_US;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      rs_out_r <= rs_r;
      nibble_r <= nib;
      pre_r    <= cw.pre_long ? PRE_PWRUP_US : 16'd0;
      post_r   <= post_us;
      last_r   <= cw.last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_register_select = rs_out_r;
  assign out_nibble          = nibble_r;
  assign out_pre_wait_us     = pre_r;
  assign out_post_wait_us    = post_r;
  assign out_last            = last_r;

endmodule
